// ===== hw/rtl/dfmb_pkg.sv =====
// Shared types and constants for the deduplicating FIFO queue.
`timescale 1ns / 1ps

package dfmb_pkg;

   localparam int ITEMS  = 256;
   localparam int ITEM_W = 8;
   localparam int ADDR_W = $clog2(ITEMS);

   typedef logic [ITEM_W-1:0] item_type;
   typedef logic [ADDR_W-1:0] idx_type;

   typedef enum logic {
      KIND_PUT,
      KIND_GET
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_APPENDED,
      STATUS_MOVED,
      STATUS_GET_DONE,
      STATUS_GET_EMPTY
   } status_type;

   typedef struct packed {
      kind_type kind;
      item_type item_value;
   } req_type;

   typedef struct packed {
      status_type status;
      item_type   item_out;
      logic       queue_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_APPEND
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_READ,
      ACT_APPEND_NEW,
      ACT_GET_LAST,
      ACT_GET_NEXT,
      ACT_MOVE_HEAD,
      ACT_UNLINK,
      ACT_MOVE_TAIL
   } action_type;

   typedef struct packed {
      action_type action;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_get;
      logic item_ok;
      logic present;
      logic is_head;
      logic is_tail;
      logic nonempty;
      logic single;
   } flags_type;

   function automatic logic item_in_range(item_type v);
      return int'(v) < ITEMS;
   endfunction

endpackage

// ===== hw/rtl/dedup_fifo_move_to_back.sv =====
// Top level of the deduplicating FIFO queue with move-to-tail on re-insert.
//
// A transaction is taken when start is high and busy is low. Its single result
// appears on rsp_data for one cycle with rsp_strobe high and must be captured
// then, since the block cannot be held off. A put of a new item, a put of the
// tail item, a get on an empty queue and a get of the only queued item are
// answered from the exec state, any other get and a put of the head item from
// the read state, and a put of an item in the middle from the append state,
// as the prev and next link RAMs have a registered read and one write port.
// Busy falls in the cycle the result is shown, so the next transaction may be
// taken then.
`timescale 1ns / 1ps

module dedup_fifo_move_to_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dfmb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dfmb_pkg::rsp_type rsp_data
);

   import dfmb_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   dfmb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   dfmb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hw/rtl/dfmb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dfmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dfmb_ctrl.sv =====
// Controller state machine that sequences each queue transaction.
`timescale 1ns / 1ps

module dfmb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dfmb_pkg::flags_type flags,
   output dfmb_pkg::cmd_type  cmd,
   output logic               busy
);

   import dfmb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (flags.is_get) begin
               state_in = (flags.nonempty && !flags.single) ? S_READ : S_IDLE;
            end else if (flags.item_ok && flags.present && !flags.is_tail) begin
               state_in = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = (!flags.is_get && !flags.is_head) ? S_APPEND : S_IDLE;
         end
         S_APPEND: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.action  = ACT_NONE;
      cmd.respond = 1'b0;
      cmd.status  = STATUS_APPENDED;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.action = ACT_LOAD;
            end
         end
         S_EXEC: begin
            priority if (flags.is_get && !flags.nonempty) begin
               cmd.respond = 1'b1;
               cmd.status  = STATUS_GET_EMPTY;
            end else if (flags.is_get && flags.single) begin
               cmd.action  = ACT_GET_LAST;
               cmd.respond = 1'b1;
               cmd.status  = STATUS_GET_DONE;
            end else if (flags.is_get) begin
               cmd.action = ACT_READ;
            end else if (!flags.item_ok) begin
               cmd.respond = 1'b1;
               cmd.status  = STATUS_APPENDED;
            end else if (!flags.present) begin
               cmd.action  = ACT_APPEND_NEW;
               cmd.respond = 1'b1;
               cmd.status  = STATUS_APPENDED;
            end else if (flags.is_tail) begin
               cmd.respond = 1'b1;
               cmd.status  = STATUS_MOVED;
            end else begin
               cmd.action = ACT_READ;
            end
         end
         S_READ: begin
            priority if (flags.is_get) begin
               cmd.action  = ACT_GET_NEXT;
               cmd.respond = 1'b1;
               cmd.status  = STATUS_GET_DONE;
            end else if (flags.is_head) begin
               cmd.action  = ACT_MOVE_HEAD;
               cmd.respond = 1'b1;
               cmd.status  = STATUS_MOVED;
            end else begin
               cmd.action = ACT_UNLINK;
            end
         end
         S_APPEND: begin
            cmd.action  = ACT_MOVE_TAIL;
            cmd.respond = 1'b1;
            cmd.status  = STATUS_MOVED;
         end
         default: cmd.action = ACT_NONE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/dfmb_datapath.sv =====
// Datapath with presence bits, head and tail marks, link RAMs and result register.
`timescale 1ns / 1ps

module dfmb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dfmb_pkg::req_type   req_data,
   input  dfmb_pkg::cmd_type   cmd,
   output dfmb_pkg::flags_type flags,
   output logic                rsp_strobe,
   output dfmb_pkg::rsp_type   rsp_data
);

   import dfmb_pkg::*;

   kind_type         op_kind_ff, op_kind_in;
   item_type         op_item_ff, op_item_in;
   idx_type          head_ff, head_in;
   idx_type          tail_ff, tail_in;
   logic             nonempty_ff, nonempty_in;
   logic [ITEMS-1:0] present_ff, present_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   idx_type op_idx;
   logic    rd_en;
   idx_type prev_rd_addr, next_rd_addr;
   idx_type prev_rd_data, next_rd_data;
   logic    prev_wr_en, next_wr_en;
   idx_type prev_wr_addr, next_wr_addr;
   idx_type prev_wr_data, next_wr_data;

   assign op_idx = idx_type'(op_item_ff);

   dfmb_ram #(.WIDTH(ADDR_W), .DEPTH(ITEMS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (rd_en),
      .rd_addr (prev_rd_addr),
      .rd_data (prev_rd_data)
   );

   dfmb_ram #(.WIDTH(ADDR_W), .DEPTH(ITEMS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (rd_en),
      .rd_addr (next_rd_addr),
      .rd_data (next_rd_data)
   );

   always_comb begin
      flags.is_get   = (op_kind_ff == KIND_GET);
      flags.item_ok  = item_in_range(op_item_ff);
      flags.present  = present_ff[op_idx];
      flags.is_head  = (op_idx == head_ff);
      flags.is_tail  = (op_idx == tail_ff);
      flags.nonempty = nonempty_ff;
      flags.single   = (head_ff == tail_ff);
   end

   assign rd_en        = (cmd.action == ACT_READ);
   assign prev_rd_addr = op_idx;
   assign next_rd_addr = (op_kind_ff == KIND_GET) ? head_ff : op_idx;

   always_comb begin
      op_kind_in   = op_kind_ff;
      op_item_in   = op_item_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      present_in   = present_ff;
      prev_wr_en   = 1'b0;
      prev_wr_addr = op_idx;
      prev_wr_data = tail_ff;
      next_wr_en   = 1'b0;
      next_wr_addr = tail_ff;
      next_wr_data = op_idx;
      unique case (cmd.action)
         ACT_LOAD: begin
            op_kind_in = req_data.kind;
            op_item_in = req_data.item_value;
         end
         ACT_APPEND_NEW: begin
            present_in[op_idx] = 1'b1;
            prev_wr_en         = 1'b1;
            next_wr_en         = nonempty_ff;
            if (!nonempty_ff) begin
               head_in = op_idx;
            end
            nonempty_in = 1'b1;
            tail_in     = op_idx;
         end
         ACT_GET_LAST: begin
            present_in[head_ff] = 1'b0;
            nonempty_in         = 1'b0;
         end
         ACT_GET_NEXT: begin
            present_in[head_ff] = 1'b0;
            head_in             = next_rd_data;
         end
         ACT_MOVE_HEAD: begin
            head_in    = next_rd_data;
            prev_wr_en = 1'b1;
            next_wr_en = 1'b1;
            tail_in    = op_idx;
         end
         ACT_UNLINK: begin
            next_wr_en   = 1'b1;
            next_wr_addr = prev_rd_data;
            next_wr_data = next_rd_data;
            prev_wr_en   = 1'b1;
            prev_wr_addr = next_rd_data;
            prev_wr_data = prev_rd_data;
         end
         ACT_MOVE_TAIL: begin
            prev_wr_en = 1'b1;
            next_wr_en = 1'b1;
            tail_in    = op_idx;
         end
         ACT_NONE, ACT_READ: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_strobe_in           = cmd.respond;
      rsp_data_in.status      = cmd.status;
      rsp_data_in.item_out    = (cmd.status == STATUS_GET_DONE) ? item_type'(head_ff) : '0;
      rsp_data_in.queue_empty = !nonempty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         nonempty_ff   <= 1'b0;
         present_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         nonempty_ff   <= nonempty_in;
         present_ff    <= present_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff  <= op_kind_in;
      op_item_ff  <= op_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== hw/rtl/dfmb_checker.sv =====
// Port-level assertions for the deduplicating FIFO queue, bound to the top level.
`timescale 1ns / 1ps

module dfmb_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input dfmb_pkg::rsp_type rsp_data
);

   import dfmb_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results arrived in back-to-back cycles");

   a_empty_get: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_GET_EMPTY
      |-> rsp_data.item_out == '0 && rsp_data.queue_empty)
      else $error("get on empty queue reported wrong fields");

   a_put_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == STATUS_APPENDED || rsp_data.status == STATUS_MOVED)
      |-> rsp_data.item_out == '0)
      else $error("put returned a nonzero item");

   a_moved_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_MOVED |-> !rsp_data.queue_empty)
      else $error("move reported an empty queue");

endmodule

bind dedup_fifo_move_to_back dfmb_checker u_dfmb_checker (.*);
